>>> design/bisection_tree_region_bounds_defines.svh
// ----------------------------------------------------------------------------
// Bisection tree region bounds: assertion macros
// Concurrent checks on clk with rst as the disable condition.
// ----------------------------------------------------------------------------
`ifndef BISECTION_TREE_REGION_BOUNDS_DEFINES_SVH
`define BISECTION_TREE_REGION_BOUNDS_DEFINES_SVH

`ifndef SYNTHESIS

`define BTRB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define BTRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BTRB_ASSERT_SAME(lbl, ante, cons, msg)

`define BTRB_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> design/btrb_pkg.sv
// ----------------------------------------------------------------------------
// btrb_pkg
// Shared codes and types of the bisection tree region bounds block.
// ----------------------------------------------------------------------------
package btrb_pkg;

  localparam int NODE_COUNT = 256;
  localparam int NODE_IDX_W = 8;
  localparam int PART_W     = 8;

  // Request codes of an input word.
  localparam logic [1:0] REQ_NODE  = 2'd0;
  localparam logic [1:0] REQ_REMAP = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_NUM_PARTS = 2'd0;
  localparam logic [1:0] CFG_NUM_DIMS  = 2'd1;
  localparam logic [1:0] CFG_REMAP_EN  = 2'd2;
  localparam logic [1:0] CFG_CUTS_KEPT = 2'd3;

  // Cut axis codes.
  localparam logic signed [2:0] AXIS_NONE = -3'sd1;
  localparam logic signed [2:0] AXIS_X    = 3'sd0;
  localparam logic signed [2:0] AXIS_Y    = 3'sd1;
  localparam logic signed [2:0] AXIS_Z    = 3'sd2;

  // Axis and child links of one tree node.
  typedef struct packed {
    logic signed [2:0]       axis;
    logic [NODE_IDX_W-1:0]   left;
    logic [NODE_IDX_W-1:0]   right;
  } node_link_t;

  // Write request into the node memory.
  typedef struct packed {
    logic                    en;
    logic [NODE_IDX_W-1:0]   idx;
    node_link_t              link;
  } node_wr_t;

endpackage

>>> design/bisection_tree_region_bounds.sv
// A rejected query ends at once; else remap slots are scanned when remapping is on
// (up to min(num_parts, MAX_PARTS, 256)), then the tree is walked (max 256 nodes).
// A result waits in an output register; the next word is taken meanwhile.
// Synchronous reset clears the control state and sets the configuration registers
// to one part, three dims, remap off and cuts not kept; every tree node then reads
// as "no cut", remap slots are undefined until written.
`include "bisection_tree_region_bounds_defines.svh"
// ----------------------------------------------------------------------------
// bisection_tree_region_bounds
// Keeps a bisection cut tree and a part remap table, and walks the tree to
// give the bounding box of a queried part.
// ----------------------------------------------------------------------------
module bisection_tree_region_bounds
  import btrb_pkg::*;
#(
  parameter int MAX_PARTS   = 256,
  parameter int COORD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [7:0]         slot_index,
  input  logic signed [2:0]  cut_axis,
  input  logic signed [31:0] cut_coord,
  input  logic [7:0]         left_child,
  input  logic [7:0]         right_child,
  input  logic [7:0]         remap_value,
  input  logic [7:0]         query_part,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               status,
  output logic signed [2:0]  dims_out,
  output logic signed [31:0] x_low,
  output logic signed [31:0] y_low,
  output logic signed [31:0] z_low,
  output logic signed [31:0] x_high,
  output logic signed [31:0] y_high,
  output logic signed [31:0] z_high
);

  localparam int REMAP_DEPTH = (MAX_PARTS < 256) ? MAX_PARTS : 256;
  localparam int RIDX_W      = $clog2(REMAP_DEPTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_ROOT = 3'd2;
  localparam logic [2:0] ST_WALK = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

  // Configuration registers.
  logic [8:0] num_parts;
  logic [1:0] num_dims;
  logic       remap_enable;
  logic       cuts_kept;

  // Query control.
  logic [2:0]            state;
  logic [PART_W-1:0]     part;
  logic [RIDX_W-1:0]     scan_idx;
  logic [NODE_IDX_W-1:0] cur_node;
  logic [NODE_IDX_W-1:0] visits;
  logic                  is_err;
  logic [COORD_WIDTH-1:0] lo [3];
  logic [COORD_WIDTH-1:0] hi [3];

  // Remap memory.
  logic [7:0]        remap_mem [REMAP_DEPTH];
  logic [7:0]        remap_q;
  logic              remap_we;
  logic [RIDX_W-1:0] remap_raddr;

  // Node memory.
  node_wr_t               node_wr;
  logic [NODE_IDX_W-1:0]  node_raddr;
  node_link_t             rd_link;
  logic [COORD_WIDTH-1:0] rd_coord;

  logic                  in_fire;
  logic                  scan_hit;
  logic                  scan_last;
  logic                  go_right;
  logic                  axis_ok;
  logic [NODE_IDX_W-1:0] next_node;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign remap_we    = in_fire && (req_type == REQ_REMAP) &&
                       ({1'b0, slot_index} < 9'(REMAP_DEPTH));
  assign remap_raddr = (state == ST_SCAN) ? RIDX_W'(scan_idx + 1'b1) : '0;

  always_ff @(posedge clk) begin
    if (remap_we) begin
      remap_mem[slot_index[RIDX_W-1:0]] <= remap_value;
    end
    remap_q <= remap_mem[remap_raddr];
  end

  // The scan stops at the first slot holding the part, or at the last slot.
  assign scan_hit  = (remap_q == part);
  assign scan_last = ((9'(scan_idx) + 9'd1) >= num_parts) ||
                     (scan_idx == RIDX_W'(REMAP_DEPTH - 1));

  assign node_wr.en   = in_fire && (req_type == REQ_NODE);
  assign node_wr.idx  = slot_index;
  assign node_wr.link = '{axis: cut_axis, left: left_child, right: right_child};

  assign go_right  = (part >= cur_node);
  assign next_node = go_right ? rd_link.right : rd_link.left;
  assign axis_ok   = (rd_link.axis == AXIS_X) || (rd_link.axis == AXIS_Y) ||
                     (rd_link.axis == AXIS_Z);

  // The next node address comes straight from the read data, so the walk
  // visits one node per cycle.
  always_comb begin
    unique case (state)
      ST_ROOT: node_raddr = rd_link.right;
      ST_WALK: node_raddr = next_node;
      default: node_raddr = '0;
    endcase
  end

  btrb_node_mem #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_node_mem (
    .clk      (clk),
    .rst      (rst),
    .wr       (node_wr),
    .wr_coord (COORD_WIDTH'(cut_coord)),
    .rd_idx   (node_raddr),
    .rd_link  (rd_link),
    .rd_coord (rd_coord)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      num_parts    <= 9'd1;
      num_dims     <= 2'd3;
      remap_enable <= 1'b0;
      cuts_kept    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUM_PARTS: num_parts    <= cfg_data;
          CFG_NUM_DIMS:  num_dims     <= cfg_data[1:0];
          CFG_REMAP_EN:  remap_enable <= cfg_data[0];
          CFG_CUTS_KEPT: cuts_kept    <= cfg_data[0];
          default:       num_parts    <= num_parts;
        endcase
      end

      // A finished query reloads the output register in the same cycle.
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_fire && (req_type == REQ_QUERY)) begin
            part   <= query_part;
            is_err <= !cuts_kept || ({1'b0, query_part} >= num_parts);
            for (int a = 0; a < 3; a++) begin
              lo[a] <= COORD_MIN;
              hi[a] <= COORD_MAX;
            end
            if (!cuts_kept || ({1'b0, query_part} >= num_parts)) begin
              state  <= ST_DONE;
            end else if (remap_enable) begin
              scan_idx <= '0;
              state    <= ST_SCAN;
            end else begin
              state <= ST_ROOT;
            end
          end
        end
        ST_SCAN: begin
          if (scan_hit) begin
            part  <= PART_W'(scan_idx);
            state <= ST_ROOT;
          end else if (scan_last) begin
            state <= ST_ROOT;
          end else begin
            scan_idx <= RIDX_W'(scan_idx + 1'b1);
          end
        end
        ST_ROOT: begin
          if (rd_link.axis[2]) begin
            is_err <= 1'b1;
            state  <= ST_DONE;
          end else if (rd_link.right == '0) begin
            for (int a = 0; a < 3; a++) begin
              lo[a] <= '0;
              hi[a] <= '0;
            end
            state <= ST_DONE;
          end else begin
            cur_node <= rd_link.right;
            visits   <= '0;
            state    <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (axis_ok) begin
            if (go_right) begin
              lo[rd_link.axis[1:0]] <= rd_coord;
            end else begin
              hi[rd_link.axis[1:0]] <= rd_coord;
            end
          end
          visits   <= NODE_IDX_W'(visits + 1'b1);
          cur_node <= next_node;
          if ((next_node == '0) || (visits == NODE_IDX_W'(NODE_COUNT - 1))) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status    <= is_err;
            dims_out  <= is_err ? -3'sd1 : signed'({1'b0, num_dims});
            x_low     <= 32'(lo[0]);
            y_low     <= 32'(lo[1]);
            z_low     <= 32'(lo[2]);
            x_high    <= 32'(hi[0]);
            y_high    <= 32'(hi[1]);
            z_high    <= 32'(hi[2]);
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `BTRB_ASSERT_NEXT(a_query_leaves_idle, in_fire && (req_type == REQ_QUERY), state != ST_IDLE, "query word did not start a walk")
  `BTRB_ASSERT_NEXT(a_done_delivers, (state == ST_DONE) && (!out_valid || out_ready), out_valid && (state == ST_IDLE), "finished query did not load the output register")
  `BTRB_ASSERT_SAME(a_err_dims, out_valid, (status == 1'b1) == (dims_out == -3'sd1), "status and dims disagree")

endmodule

>>> design/btrb_node_mem.sv
// ----------------------------------------------------------------------------
// btrb_node_mem
// Tree node memory with one write and one registered read port. A node that
// was never written since reset reads as "no cut, coordinate 0, no children".
// ----------------------------------------------------------------------------
module btrb_node_mem
  import btrb_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  node_wr_t               wr,
  input  logic [COORD_WIDTH-1:0] wr_coord,
  input  logic [NODE_IDX_W-1:0]  rd_idx,
  output node_link_t             rd_link,
  output logic [COORD_WIDTH-1:0] rd_coord
);

  node_link_t             link_mem  [NODE_COUNT];
  logic [COORD_WIDTH-1:0] coord_mem [NODE_COUNT];
  logic [NODE_COUNT-1:0]  written;
  node_link_t             link_q;
  logic [COORD_WIDTH-1:0] coord_q;
  logic                   rd_written;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      link_mem[wr.idx]  <= wr.link;
      coord_mem[wr.idx] <= wr_coord;
    end
    link_q  <= link_mem[rd_idx];
    coord_q <= coord_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.idx] <= 1'b1;
      end
      rd_written <= written[rd_idx];
    end
  end

  assign rd_link  = rd_written ? link_q
                               : node_link_t'{axis: AXIS_NONE, left: '0, right: '0};
  assign rd_coord = rd_written ? coord_q : '0;

endmodule

>>> test/tb_bisection_tree_region_bounds.sv
// ----------------------------------------------------------------------------
// tb_bisection_tree_region_bounds
// Fills the cut tree and the remap table, asks for region boxes and checks
// every returned box against a local prediction, under random idle cycles.
// ----------------------------------------------------------------------------
module tb_bisection_tree_region_bounds;
  import btrb_pkg::*;

  localparam logic [1:0] REQ_IGNORED = 2'd3;
  localparam logic signed [2:0] AXIS_ODD_POS = 3'sb011;
  localparam logic signed [2:0] AXIS_ODD_NEG = 3'sb100;
  localparam logic [31:0] COORD_MIN = 32'h8000_0000;
  localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam int DRAIN_CYCLES = 600;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  slot;
    logic [2:0]  axis;
    logic [31:0] coord;
    logic [7:0]  left;
    logic [7:0]  right;
    logic [7:0]  remap_val;
    logic [7:0]  part;
  } req_word_t;

  typedef struct packed {
    logic            status;
    logic [2:0]      dims;
    logic [2:0][31:0] lo;
    logic [2:0][31:0] hi;
  } box_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [8:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         req_type = '0;
  logic [7:0]         slot_index = '0;
  logic signed [2:0]  cut_axis = '0;
  logic signed [31:0] cut_coord = '0;
  logic [7:0]         left_child = '0;
  logic [7:0]         right_child = '0;
  logic [7:0]         remap_value = '0;
  logic [7:0]         query_part = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               status;
  logic signed [2:0]  dims_out;
  logic signed [31:0] x_low;
  logic signed [31:0] y_low;
  logic signed [31:0] z_low;
  logic signed [31:0] x_high;
  logic signed [31:0] y_high;
  logic signed [31:0] z_high;

  bisection_tree_region_bounds dut (.*);

  // Local copy of the block's tables and registers.
  logic signed [2:0] node_axis [NODE_COUNT];
  logic [31:0]       node_cut [NODE_COUNT];
  logic [7:0]        node_left [NODE_COUNT];
  logic [7:0]        node_right [NODE_COUNT];
  logic [7:0]        remap_tbl [NODE_COUNT];
  logic [8:0]        parts_in_use = 9'd1;
  logic [1:0]        dims_cfg = 2'd3;
  logic              remap_on = 1'b0;
  logic              cuts_on = 1'b0;

  req_word_t req_words [$];
  req_word_t cur_word;
  box_t      boxes_due [$];
  box_t      got_box;
  box_t      want_box;
  bit        word_busy = 1'b0;
  int        words_queued = 0;
  int        fault_count = 0;
  int        quiet_cycles = 0;
  int        idle_pct = 37;
  int        stall_pct = 37;
  string     axis_tag [3] = '{"x", "y", "z"};

  always #10 clk = ~clk;

  function automatic box_t predict_box(logic [7:0] asked);
    box_t b;
    bit   err;
    int   part, node, visits, ax, i;
    err = 1'b0;
    part = asked;
    b.status = 1'b0;
    b.dims = {1'b0, dims_cfg};
    for (i = 0; i < 3; i++) begin
      b.lo[i] = COORD_MIN;
      b.hi[i] = COORD_MAX;
    end
    if (!cuts_on || part >= parts_in_use) begin
      err = 1'b1;
    end else begin
      // The lowest slot holding the part gives its new number.
      if (remap_on) begin
        for (i = 0; i < parts_in_use && i < NODE_COUNT; i++) begin
          if (remap_tbl[i] == part) begin
            part = i;
            break;
          end
        end
      end
      if (node_axis[0] < 0) begin
        err = 1'b1;
      end else if (node_right[0] == 0) begin
        for (i = 0; i < 3; i++) begin
          b.lo[i] = '0;
          b.hi[i] = '0;
        end
      end else begin
        node = node_right[0];
        visits = 0;
        while (node != 0 && visits < NODE_COUNT) begin
          ax = node_axis[node];
          visits++;
          if (part >= node) begin
            if (ax >= 0 && ax <= 2) b.lo[ax] = node_cut[node];
            node = node_right[node];
          end else begin
            if (ax >= 0 && ax <= 2) b.hi[ax] = node_cut[node];
            node = node_left[node];
          end
        end
      end
    end
    if (err) begin
      b.status = 1'b1;
      b.dims = 3'b111;
    end
    return b;
  endfunction

  function automatic void apply_word(req_word_t w);
    case (w.kind)
      REQ_NODE: begin
        node_axis[w.slot] = w.axis;
        node_cut[w.slot] = w.coord;
        node_left[w.slot] = w.left;
        node_right[w.slot] = w.right;
      end
      REQ_REMAP: remap_tbl[w.slot] = w.remap_val;
      REQ_QUERY: boxes_due.push_back(predict_box(w.part));
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // Unused fields carry random bits so that every input bit toggles.
  function automatic req_word_t filler_word(logic [1:0] kind);
    req_word_t w;
    w.kind = kind;
    w.slot = 8'($urandom);
    w.axis = 3'($urandom);
    w.coord = $urandom;
    w.left = 8'($urandom);
    w.right = 8'($urandom);
    w.remap_val = 8'($urandom);
    w.part = 8'($urandom);
    return w;
  endfunction

  function automatic void queue_word(req_word_t w);
    req_words.push_back(w);
    if (w.kind != REQ_IGNORED) words_queued++;
  endfunction

  function automatic void push_node(logic [7:0] slot, logic [2:0] axis, logic [31:0] coord,
                                    logic [7:0] left, logic [7:0] right);
    req_word_t w;
    w = filler_word(REQ_NODE);
    w.slot = slot;
    w.axis = axis;
    w.coord = coord;
    w.left = left;
    w.right = right;
    queue_word(w);
  endfunction

  function automatic void push_remap(logic [7:0] slot, logic [7:0] value);
    req_word_t w;
    w = filler_word(REQ_REMAP);
    w.slot = slot;
    w.remap_val = value;
    queue_word(w);
  endfunction

  function automatic void push_query(logic [7:0] part);
    req_word_t w;
    w = filler_word(REQ_QUERY);
    w.part = part;
    queue_word(w);
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(11))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Splits parts [lo_part, hi_part) at a random node number; returns that
  // node, or 0 when the range holds a single part.
  function automatic int add_split(int lo_part, int hi_part);
    int m, lc, rc;
    if (hi_part - lo_part < 2) return 0;
    m = $urandom_range(hi_part - 1, lo_part + 1);
    lc = add_split(lo_part, m);
    rc = add_split(m, hi_part);
    push_node(8'(m), 3'($urandom_range(2)), rand_coord(), 8'(lc), 8'(rc));
    return m;
  endfunction

  function automatic void build_tree(int parts);
    push_node(8'd0, 3'($urandom_range(2)), rand_coord(), 8'($urandom),
              8'(add_split(0, parts)));
  endfunction

  task automatic write_reg(logic [1:0] index, int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= 9'(value);
    case (index)
      CFG_NUM_PARTS: parts_in_use = 9'(value);
      CFG_NUM_DIMS:  dims_cfg = 2'(value);
      CFG_REMAP_EN:  remap_on = 1'(value);
      CFG_CUTS_KEPT: cuts_on = 1'(value);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Returns once every word is taken, every box has come back and the block
  // has had time to finish any trailing write.
  task automatic wait_idle();
    while (req_words.size() != 0 || word_busy || boxes_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(int parts, int dims, bit remap, bit cuts, int count, bit no_idle);
    int r, stop;
    wait_idle();
    write_reg(CFG_NUM_PARTS, parts);
    write_reg(CFG_NUM_DIMS, dims);
    write_reg(CFG_REMAP_EN, remap);
    write_reg(CFG_CUTS_KEPT, cuts);
    idle_pct = no_idle ? 0 : 37;
    stall_pct = no_idle ? 0 : 37;
    stop = words_queued + count;
    build_tree(parts);
    while (words_queued < stop) begin
      r = $urandom_range(99);
      if (r < 75)
        push_query(r < 67 ? 8'($urandom_range(parts - 1)) : 8'($urandom));
      else if (r < 85)
        push_remap(8'($urandom), r < 82 ? 8'($urandom_range(parts - 1)) : 8'($urandom));
      else if (r < 90)
        push_node(8'($urandom), 3'($urandom), rand_coord(), 8'($urandom), 8'($urandom));
      else if (r < 92)
        build_tree(parts);
      else
        queue_word(filler_word(REQ_IGNORED));
    end
  endtask

  // Sender: holds a word until it is taken, then loads the next one.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!word_busy) begin
      if (req_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cur_word = req_words.pop_front();
        word_busy = 1'b1;
        in_valid <= 1'b1;
        req_type <= cur_word.kind;
        slot_index <= cur_word.slot;
        cut_axis <= cur_word.axis;
        cut_coord <= cur_word.coord;
        left_child <= cur_word.left;
        right_child <= cur_word.right;
        remap_value <= cur_word.remap_val;
        query_part <= cur_word.part;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      apply_word(cur_word);
      word_busy = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_box.status = status;
      got_box.dims = dims_out;
      got_box.lo = {z_low, y_low, x_low};
      got_box.hi = {z_high, y_high, x_high};
      if (boxes_due.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("%0t: box returned with none outstanding", $time);
      end else begin
        want_box = boxes_due.pop_front();
        check_field("status", want_box.status, got_box.status);
        check_field("dims_out", want_box.dims, got_box.dims);
        for (int i = 0; i < 3; i++) begin
          check_field({axis_tag[i], "_low"}, want_box.lo[i], got_box.lo[i]);
          check_field({axis_tag[i], "_high"}, want_box.hi[i], got_box.hi[i]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int perm [NODE_COUNT];
    int i, j, t;
    for (i = 0; i < NODE_COUNT; i++) begin
      node_axis[i] = AXIS_NONE;
      node_cut[i] = '0;
      node_left[i] = '0;
      node_right[i] = '0;
      remap_tbl[i] = '0;
    end
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Every remap slot gets a value first, so a remap search never reads an
    // unwritten slot.
    for (i = 0; i < NODE_COUNT; i++) perm[i] = i;
    for (i = NODE_COUNT - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (i = 0; i < NODE_COUNT; i++) push_remap(8'(i), 8'(perm[i]));
    // Reset settings: cuts not kept, and only part 0 in use.
    push_query(8'd0);
    push_query(8'd255);
    queue_word(filler_word(REQ_IGNORED));

    wait_idle();
    write_reg(CFG_CUTS_KEPT, 1);
    write_reg(CFG_NUM_PARTS, 256);
    write_reg(CFG_NUM_DIMS, 1);
    push_query(8'd5);
    push_node(8'd0, AXIS_X, 32'h0, 8'd0, 8'd0);
    push_query(8'd0);
    push_node(8'd0, AXIS_Z, 32'h1234_5678, 8'd0, 8'd128);
    push_node(8'd128, AXIS_X, COORD_MAX, 8'd64, 8'd192);
    push_node(8'd64, AXIS_Y, COORD_MIN, 8'd0, 8'd96);
    push_node(8'd96, AXIS_Z, 32'hFFFF_FFFF, 8'd0, 8'd0);
    push_node(8'd192, AXIS_ODD_POS, 32'h0001_0000, 8'd0, 8'd224);
    push_node(8'd224, AXIS_ODD_NEG, 32'h0002_0000, 8'd0, 8'd0);
    push_query(8'd0);
    push_query(8'd63);
    push_query(8'd64);
    push_query(8'd100);
    push_query(8'd128);
    push_query(8'd200);
    push_query(8'd255);
    // A node that names itself as its upper child makes the walk run out.
    push_node(8'd224, AXIS_Y, 32'hFFFF_0000, 8'd0, 8'd224);
    push_query(8'd250);

    wait_idle();
    write_reg(CFG_REMAP_EN, 1);
    write_reg(CFG_NUM_PARTS, 200);
    write_reg(CFG_NUM_DIMS, 2);
    push_remap(8'd0, 8'd199);
    push_query(8'd199);
    push_query(8'd200);
    push_query(8'd0);

    run_phase(256, 3, 1'b0, 1'b1, 200, 1'b0);
    run_phase(1, 1, 1'b1, 1'b1, 100, 1'b0);
    run_phase(256, 2, 1'b1, 1'b1, 250, 1'b1);
    run_phase($urandom_range(255, 2), 3, 1'b0, 1'b1, 200, 1'b0);
    run_phase($urandom_range(255, 2), 1, 1'b1, 1'b0, 80, 1'b0);
    run_phase(128, 2, 1'b1, 1'b1, 200, 1'b0);
    run_phase($urandom_range(255, 2), 3, 1'b0, 1'b1, 200, 1'b0);

    wait_idle();
    if (fault_count == 0 && boxes_due.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
